>>> rtl/rhcb_pkg.sv
package rhcb_pkg;

    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 25;
    localparam int OFS_W             = 24;
    localparam int CLEN_W            = 25;
    localparam int CNUM_W            = 32;
    localparam int HASH_W            = 32;
    localparam int CFG_W             = 16;
    localparam int CFG_IDX_W         = 1;
    localparam int XOR_SHIFT         = 5;
    localparam int DIV_STEPS         = HASH_W;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
    localparam int WINDOW_SIZE_DEF   = 7;
    localparam int POSITION_BITS_DEF = 24;

    localparam logic [CFG_W-1:0] HASH_MOD_RST   = CFG_W'(64);
    localparam logic [CFG_W-1:0] SKIP_BYTES_RST = CFG_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_MOD   = 1'b0,
        CFG_SKIP_BYTES = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROLL,
        ST_HASH,
        ST_DIV,
        ST_DECIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic out_busy;
        logic out_load;
    } t_ctrl;

endpackage

>>> rtl/rhcb_ifs.sv
interface rhcb_in_if;
    import rhcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  buffer_length;

    modport source (output valid, output byte_value, output buffer_length, input ready);
    modport sink   (input valid, input byte_value, input buffer_length, output ready);
endinterface

interface rhcb_out_if;
    import rhcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OFS_W-1:0]  chunk_start;
    logic [OFS_W-1:0]  chunk_end;
    logic [CLEN_W-1:0] chunk_length;
    logic [CNUM_W-1:0] chunk_number;
    logic [HASH_W-1:0] hash_value;

    modport source (
        output valid, output chunk_start, output chunk_end, output chunk_length,
        output chunk_number, output hash_value, input ready
    );
    modport sink (
        input valid, input chunk_start, input chunk_end, input chunk_length,
        input chunk_number, input hash_value, output ready
    );
endinterface

>>> rtl/rolling_hash_chunk_boundary_unit.sv
// Rolling-hash chunk boundary unit.
// i_byte carries one byte of a buffer per item with the buffer's length.
// o_chunk carries one item per chunk boundary: start, end, length,
// running chunk number and the hash at the boundary byte.
// The configuration port writes the hash modulus (index 0) and skip_bytes
// (index 1); write only while the unit is idle.
// A hashed byte passes through these steps before the next one is taken:
// the accept step (ST_IDLE) that launches the window read, ST_ROLL for the
// sums, ST_HASH for the hash, ST_DIV for the restoring divider that reduces
// the hash modulo the hash modulus, ST_DECIDE for the boundary decision and
// ST_FINISH for the position update. A byte in a skip run goes from the
// accept step straight to ST_FINISH. Boundary items load in ST_DECIDE.
// Results sit in an output register; the unit accepts further bytes while
// it waits, each only once the last is finished. A new boundary waits in
// the decision cycle while that register is still held by a stalled receiver.
// Reset (synchronous, active low) clears the rolling hash sums, window and
// position state, the chunk counter and the output valid, and loads a hash
// modulus of 64 and skip_bytes 16.
module rolling_hash_chunk_boundary_unit #(
    parameter int WINDOW_SIZE   = rhcb_pkg::WINDOW_SIZE_DEF,
    parameter int POSITION_BITS = rhcb_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rhcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rhcb_pkg::CFG_W-1:0]     i_cfg_data,
    rhcb_in_if.sink                        i_byte,
    rhcb_out_if.source                     o_chunk
);
    import rhcb_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_SIZE);
    localparam int CMP_W = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [CFG_W-1:0] r_hash_mod, r_skip_bytes;

    logic [BYTE_W-1:0] r_win_mem [WINDOW_SIZE];
    logic [BYTE_W-1:0] r_win_rd;
    logic [WINDOW_SIZE-1:0] r_win_vld;
    logic [PTR_W-1:0]  r_wptr;

    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  r_len;
    logic [HASH_W-1:0] r_bsum, r_wsum, r_sxor, r_hash, r_dvd;
    logic [CFG_W-1:0]  r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [POSITION_BITS-1:0] r_pos, r_start;
    logic [CFG_W-1:0]  r_skip_left;
    logic [CNUM_W-1:0] r_chunk_total;

    logic              r_out_valid;
    logic [OFS_W-1:0]  r_out_start, r_out_end;
    logic [CLEN_W-1:0] r_out_len;
    logic [CNUM_W-1:0] r_out_num;
    logic [HASH_W-1:0] r_out_hash;

    logic [BYTE_W-1:0] oldest;
    logic [CFG_W:0]    rem_sh;
    logic              rem_ge;
    logic              bnd;
    logic [CMP_W-1:0]  pos_ext, start_ext, pos_inc, pos_skip, len_ext, clen_ext;
    logic [POSITION_BITS-1:0] pos_diff;
    logic              buf_end, skip_fits, in_acc;

    assign in_acc   = i_byte.valid && ctrl.in_ready;
    assign oldest   = r_win_vld[r_wptr] ? r_win_rd : '0;
    assign rem_sh   = {r_rem, r_dvd[HASH_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_hash_mod};
    assign bnd      = (r_hash_mod != '0) && (r_rem == r_hash_mod - CFG_W'(1));
    assign pos_ext  = CMP_W'(r_pos);
    assign start_ext = CMP_W'(r_start);
    assign pos_inc  = pos_ext + CMP_W'(1);
    assign pos_skip = pos_ext + CMP_W'(r_skip_bytes);
    assign len_ext  = CMP_W'(r_len);
    assign pos_diff = r_pos - r_start;
    assign clen_ext = CMP_W'(pos_diff) + CMP_W'(1);
    assign buf_end  = pos_inc >= len_ext;
    assign skip_fits = pos_skip < len_ext;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (r_skip_left != '0) ? ST_FINISH : ST_ROLL;
                end
            end
            ST_ROLL:   n_state = ST_HASH;
            ST_HASH:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!(bnd && ctrl.out_busy)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.in_ready = (r_state == ST_IDLE);
        ctrl.out_busy = r_out_valid && !o_chunk.ready;
        ctrl.out_load = (r_state == ST_DECIDE) && bnd && !ctrl.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mod   <= HASH_MOD_RST;
            r_skip_bytes <= SKIP_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_HASH_MOD:   r_hash_mod   <= i_cfg_data;
                CFG_SKIP_BYTES: r_skip_bytes <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_win_rd <= r_win_mem[r_wptr];
        if (r_state == ST_ROLL) begin
            r_win_mem[r_wptr] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_byte.byte_value;
            r_len  <= i_byte.buffer_length;
        end
        case (r_state)
            ST_HASH: begin
                r_hash <= r_bsum + r_wsum + r_sxor;
                r_dvd  <= r_bsum + r_wsum + r_sxor;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            ST_DIV: begin
                r_rem <= rem_ge ? rem_sh[CFG_W-1:0] - r_hash_mod : rem_sh[CFG_W-1:0];
                r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            default: begin
            end
        endcase
        if (ctrl.out_load) begin
            r_out_start <= start_ext[OFS_W-1:0];
            r_out_end   <= pos_ext[OFS_W-1:0];
            r_out_len   <= clen_ext[CLEN_W-1:0];
            r_out_num   <= r_chunk_total + CNUM_W'(1);
            r_out_hash  <= r_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld     <= '0;
            r_wptr        <= '0;
            r_bsum        <= '0;
            r_wsum        <= '0;
            r_sxor        <= '0;
            r_pos         <= '0;
            r_start       <= '0;
            r_skip_left   <= '0;
            r_chunk_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_chunk.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && (r_skip_left != '0)) begin
                r_skip_left <= r_skip_left - CFG_W'(1);
            end
            case (r_state)
                ST_ROLL: begin
                    r_wsum <= r_wsum - r_bsum + HASH_W'(WINDOW_SIZE) * HASH_W'(r_byte);
                    r_bsum <= r_bsum + HASH_W'(r_byte) - HASH_W'(oldest);
                    r_sxor <= (r_sxor << XOR_SHIFT) ^ HASH_W'(r_byte);
                    r_win_vld[r_wptr] <= 1'b1;
                    r_wptr <= (r_wptr == PTR_W'(WINDOW_SIZE - 1)) ? '0 : r_wptr + PTR_W'(1);
                end
                ST_DECIDE: begin
                    if (ctrl.out_load) begin
                        r_chunk_total <= r_chunk_total + CNUM_W'(1);
                        r_start       <= pos_inc[POSITION_BITS-1:0];
                        r_skip_left   <= skip_fits ? r_skip_bytes : '0;
                    end
                end
                ST_FINISH: begin
                    if (buf_end) begin
                        r_win_vld   <= '0;
                        r_wptr      <= '0;
                        r_bsum      <= '0;
                        r_wsum      <= '0;
                        r_sxor      <= '0;
                        r_pos       <= '0;
                        r_start     <= '0;
                        r_skip_left <= '0;
                    end else begin
                        r_pos <= pos_inc[POSITION_BITS-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign i_byte.ready         = ctrl.in_ready;
    assign o_chunk.valid        = r_out_valid;
    assign o_chunk.chunk_start  = r_out_start;
    assign o_chunk.chunk_end    = r_out_end;
    assign o_chunk.chunk_length = r_out_len;
    assign o_chunk.chunk_number = r_out_num;
    assign o_chunk.hash_value   = r_out_hash;

endmodule
